FILE: rtl/lphm_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// Linear-probe accumulating hash map package
// Shared types and constants: item structures, operation and status codes,
// the stored slot word, the controller state and the mixing constants.
// ---------------------------------------------------------------------------
package lphm_pkg;

  typedef enum logic {
    FUNC_GET = 1'b0,
    FUNC_ADD = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_RESERVED = 2'd2
  } status_e;

  typedef struct packed {
    func_e              func;
    logic signed [31:0] key;
    logic signed [31:0] amount;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] value_out;
    logic               found;
    status_e            status;
  } out_item_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] key;
    logic [31:0] value;
  } slot_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_MIX1,
    S_MIX2,
    S_MOD1,
    S_MOD2,
    S_MOD3,
    S_CHECK,
    S_RSVD
  } state_e;

  localparam logic [31:0] MixMulA     = 32'h85eb_ca6b;
  localparam logic [31:0] MixMulB     = 32'hc2b2_ae35;
  localparam logic [31:0] ReservedKey = 32'h8000_0000;

endpackage
`default_nettype wire

FILE: rtl/linear_probe_accumulating_hash_map_top.sv
`default_nettype none
// ---------------------------------------------------------------------------
// Linear-probe accumulating hash map, top level
// Flow: an item taken in idle passes MIX1, MIX2 (mixing), MOD1 to MOD3 (reduction
// modulo SLOTS, first slot read) and CHECK, one slot read per further probe; a
// reserved key goes to RSVD instead. A new item is taken only in idle, after the
// last result has been loaded; a stalled output holds CHECK and RSVD.
// Reset: control state clears at once, then a pass over all slots empties them.
// ---------------------------------------------------------------------------
module linear_probe_accumulating_hash_map_top #(
  parameter int unsigned SLOTS = 1021
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire lphm_pkg::in_item_t in_item_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output lphm_pkg::out_item_t     out_item_o
);
  import lphm_pkg::*;

  localparam int unsigned AW    = $clog2(SLOTS);
  localparam int unsigned RW    = AW + 1;
  localparam int unsigned Shift = 32 + AW;
  localparam int unsigned PW    = Shift + 32;
  localparam logic [63:0] MagicW = (64'd1 << Shift) / 64'(SLOTS);
  localparam logic [32:0] Magic  = MagicW[32:0];

  slot_t mem [SLOTS];
  slot_t rd_q;

  state_e state_q, state_d;

  logic [AW-1:0] pos_q, pos_d, pos_next;
  logic [AW-1:0] count_q, count_d;

  func_e       func_q;
  logic [31:0] key_q;
  logic [31:0] amount_q;
  logic [31:0] h_q;
  logic [31:0] q_q;
  logic [RW-1:0] qn_q;

  logic [31:0]     h_fin;
  logic [31:0]     h_mid;
  logic [PW-1:0]   prod;
  logic [2*RW-1:0] qn_full;
  logic [RW-1:0]   rem_raw;
  logic [RW-1:0]   rem_fix;

  logic      hit, empty, last, done, out_free;
  logic      rd_en, wr_en, out_load;
  slot_t     wr_data;
  out_item_t res;
  logic      is_add;

  logic      out_valid_q;
  out_item_t out_q;

  assign is_add   = (func_q == FUNC_ADD);
  assign out_free = !out_valid_q || out_ready_i;
  assign pos_next = (pos_q == AW'(SLOTS - 1)) ? '0 : pos_q + 1'b1;

  assign h_mid   = h_q ^ (h_q >> 13);
  assign h_fin   = h_q ^ (h_q >> 16);
  assign prod    = PW'(h_fin) * PW'(Magic);
  assign qn_full = (2*RW)'(q_q[RW-1:0]) * (2*RW)'(SLOTS);
  assign rem_raw = h_q[RW-1:0] - qn_q;
  assign rem_fix = (rem_raw >= RW'(SLOTS)) ? rem_raw - RW'(SLOTS) : rem_raw;

  assign empty = !rd_q.valid;
  assign hit   = rd_q.valid && (rd_q.key == key_q);
  assign last  = (count_q == AW'(SLOTS - 1));
  assign done  = hit || empty || last;

  always_comb begin
    res.value_out = '0;
    res.found     = 1'b0;
    res.status    = ST_OK;
    wr_data.valid = 1'b1;
    wr_data.key   = key_q;
    wr_data.value = amount_q;
    if (state_q == S_RSVD) begin
      res.status = ST_RESERVED;
    end else if (hit) begin
      res.found     = 1'b1;
      res.value_out = is_add ? rd_q.value + amount_q : rd_q.value;
      wr_data.value = rd_q.value + amount_q;
    end else if (empty) begin
      res.value_out = is_add ? amount_q : '0;
    end else if (is_add) begin
      res.status = ST_FULL;
    end
    if (state_q == S_CLEAR) begin
      wr_data.valid = 1'b0;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: begin
        if (pos_q == AW'(SLOTS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = (in_item_i.key == ReservedKey) ? S_RSVD : S_MIX1;
        end
      end
      S_MIX1: state_d = S_MIX2;
      S_MIX2: state_d = S_MOD1;
      S_MOD1: state_d = S_MOD2;
      S_MOD2: state_d = S_MOD3;
      S_MOD3: state_d = S_CHECK;
      S_CHECK: begin
        if (done && out_free) begin
          state_d = S_IDLE;
        end
      end
      S_RSVD: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    rd_en      = 1'b0;
    wr_en      = 1'b0;
    out_load   = 1'b0;
    pos_d      = pos_q;
    count_d    = count_q;
    unique case (state_q)
      S_CLEAR: begin
        wr_en = 1'b1;
        pos_d = pos_next;
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
      end
      S_MOD3: begin
        rd_en   = 1'b1;
        pos_d   = rem_fix[AW-1:0];
        count_d = '0;
      end
      S_CHECK: begin
        if (!done) begin
          rd_en   = 1'b1;
          pos_d   = pos_next;
          count_d = count_q + 1'b1;
        end else if (out_free) begin
          out_load = 1'b1;
          wr_en    = is_add && (hit || empty);
        end
      end
      S_RSVD: begin
        out_load = out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      pos_q       <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      count_q <= count_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= res;
    end
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          func_q   <= in_item_i.func;
          key_q    <= in_item_i.key;
          amount_q <= in_item_i.amount;
          h_q      <= in_item_i.key ^ (in_item_i.key >> 16);
        end
      end
      S_MIX1: h_q <= h_q * MixMulA;
      S_MIX2: h_q <= h_mid * MixMulB;
      S_MOD1: begin
        h_q <= h_fin;
        q_q <= prod[Shift +: 32];
      end
      S_MOD2: qn_q <= qn_full[RW-1:0];
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[pos_q] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[pos_d];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule
`default_nettype wire

FILE: tb/sv/linear_probe_accumulating_hash_map_top_tb.sv
// ---------------------------------------------------------------------------
// Linear-probe accumulating hash map testbench
// Drives get and add requests through the valid/ready input channel and checks
// every result against a behavioural copy of the table kept in the bench.
// Directed requests cover the reserved key, value wrap and a probe chain that
// wraps past the last slot. Random traffic then fills the table completely and
// keeps working on it, so that full-table adds and exhaustive probes occur.
// ---------------------------------------------------------------------------
module linear_probe_accumulating_hash_map_top_tb;

  import lphm_pkg::*;

  localparam int unsigned SLOTS = 1021;

  typedef struct {
    logic     drain;
    in_item_t item;
  } req_entry_t;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  req_entry_t req_q[$];
  out_item_t  pending_results[$];

  logic        tbl_valid[SLOTS];
  logic [31:0] tbl_key[SLOTS];
  logic [31:0] tbl_val[SLOTS];

  bit          known_keys[logic [31:0]];
  logic [31:0] key_list[$];

  int unsigned n_offered = 0;
  int unsigned n_accepted = 0;
  int unsigned n_results = 0;
  int unsigned n_errors = 0;
  int unsigned n_full = 0;
  int unsigned n_rsvd = 0;
  int unsigned n_hits = 0;
  int unsigned hold_left = 0;
  bit          held = 1'b0;

  linear_probe_accumulating_hash_map_top #(
    .SLOTS(SLOTS)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_item_o (out_item)
  );

  always #4 clk_i = ~clk_i;

  function automatic int unsigned home_slot(logic [31:0] k);
    logic [31:0] h;
    h = k;
    h = h ^ (h >> 16);
    h = h * MixMulA;
    h = h ^ (h >> 13);
    h = h * MixMulB;
    h = h ^ (h >> 16);
    return h % SLOTS;
  endfunction

  task automatic map_access(in_item_t req);
    out_item_t   res;
    logic [31:0] k;
    int unsigned pos;
    int unsigned n;
    bit          hit;
    bit          stop;
    res = '0;
    res.status = ST_OK;
    k = req.key;
    if (k == ReservedKey) begin
      res.status = ST_RESERVED;
    end else begin
      pos = home_slot(k);
      hit = 1'b0;
      stop = 1'b0;
      for (n = 0; n < SLOTS && !stop; n++) begin
        if (!tbl_valid[pos]) begin
          stop = 1'b1;
        end else if (tbl_key[pos] == k) begin
          hit = 1'b1;
          stop = 1'b1;
        end else begin
          pos = (pos == SLOTS - 1) ? 0 : pos + 1;
        end
      end
      if (hit) begin
        res.found = 1'b1;
        if (req.func == FUNC_ADD) tbl_val[pos] = tbl_val[pos] + req.amount;
        res.value_out = tbl_val[pos];
      end else if (req.func == FUNC_ADD) begin
        if (stop) begin
          tbl_valid[pos] = 1'b1;
          tbl_key[pos] = k;
          tbl_val[pos] = req.amount;
          res.value_out = req.amount;
        end else begin
          res.status = ST_FULL;
        end
      end
    end
    pending_results = {pending_results, res};
  endtask

  task automatic report_mismatch(string msg);
    if (n_errors < 100) $display("MISMATCH at %0t: %s", $time, msg);
    n_errors++;
  endtask

  task automatic check_result(out_item_t got);
    out_item_t want;
    n_results++;
    if (got.status == ST_FULL) n_full++;
    if (got.status == ST_RESERVED) n_rsvd++;
    if (got.found) n_hits++;
    if (pending_results.size() == 0) begin
      report_mismatch("result with no request outstanding");
      return;
    end
    want = pending_results.pop_front();
    if (got.value_out !== want.value_out)
      report_mismatch($sformatf("result %0d value_out %h, expected %h",
                                n_results, got.value_out, want.value_out));
    if (got.found !== want.found)
      report_mismatch($sformatf("result %0d found %b, expected %b",
                                n_results, got.found, want.found));
    if (got.status !== want.status)
      report_mismatch($sformatf("result %0d status %0d, expected %0d",
                                n_results, got.status, want.status));
  endtask

  function automatic logic [31:0] fresh_key(int target);
    logic [31:0] k;
    do begin
      k = $urandom;
    end while (k == ReservedKey || known_keys.exists(k) ||
               (target >= 0 && home_slot(k) != target));
    return k;
  endfunction

  function automatic logic [31:0] old_key();
    return key_list[$urandom_range(key_list.size() - 1)];
  endfunction

  function automatic logic [31:0] rand_amount();
    case ($urandom_range(7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_req(func_e f, logic [31:0] k, logic [31:0] a);
    req_entry_t e;
    e.drain = 1'b0;
    e.item.func = f;
    e.item.key = k;
    e.item.amount = a;
    req_q = {req_q, e};
    if (f == FUNC_ADD && k != ReservedKey && !known_keys.exists(k) &&
        key_list.size() < SLOTS) begin
      known_keys[k] = 1'b1;
      key_list = {key_list, k};
    end
  endtask

  task automatic queue_pause();
    req_entry_t e;
    e.drain = 1'b1;
    e.item = '0;
    req_q = {req_q, e};
  endtask

  always @(posedge clk_i) begin : p_drive
    logic     offer;
    logic     quiet;
    in_item_t nxt;
    if (rst_ni) begin
      if (in_valid && in_ready) begin
        map_access(in_item);
        n_accepted++;
      end
      if (!in_valid || in_ready) begin
        offer = 1'b0;
        nxt = in_item;
        quiet = (n_offered >= 400 && n_offered < 700);
        if (req_q.size() > 0 && req_q[0].drain) begin
          if (pending_results.size() == 0) req_q.delete(0);
        end else if (req_q.size() > 0 && (quiet || $urandom_range(99) >= 20)) begin
          offer = 1'b1;
          nxt = req_q[0].item;
          req_q.delete(0);
          n_offered++;
        end
        in_valid <= offer;
        in_item <= nxt;
      end
    end
  end

  always @(posedge clk_i) begin : p_monitor
    logic quiet;
    if (rst_ni) begin
      if (out_valid && out_ready) check_result(out_item);
      quiet = (n_results >= 400 && n_results < 700);
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (!held && n_results >= 200) begin
        held = 1'b1;
        hold_left = 400;
        out_ready <= 1'b0;
      end else begin
        out_ready <= quiet || ($urandom_range(99) >= 20);
      end
    end
  end

  initial begin
    #80_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin : p_main
    logic [31:0] c0;
    logic [31:0] c1;
    logic [31:0] c2;
    logic [31:0] c3;
    int unsigned r;
    int          i;

    for (i = 0; i < SLOTS; i++) tbl_valid[i] = 1'b0;

    queue_req(FUNC_GET, ReservedKey, $urandom);
    queue_req(FUNC_ADD, ReservedKey, 32'd5);
    queue_req(FUNC_GET, 32'h0000_0000, 32'hffff_ffff);
    queue_req(FUNC_ADD, 32'h0000_0000, 32'h7fff_ffff);
    queue_req(FUNC_ADD, 32'h0000_0000, 32'h0000_0001);
    queue_req(FUNC_ADD, 32'h0000_0000, 32'h8000_0000);
    queue_req(FUNC_GET, 32'h0000_0000, 32'h0000_0000);
    queue_req(FUNC_ADD, 32'h7fff_ffff, 32'h8000_0000);
    queue_req(FUNC_ADD, 32'hffff_ffff, 32'hffff_ffff);
    queue_req(FUNC_GET, 32'h7fff_ffff, 32'h7fff_ffff);
    c0 = fresh_key(SLOTS - 1);
    queue_req(FUNC_ADD, c0, 32'd11);
    c1 = fresh_key(SLOTS - 1);
    queue_req(FUNC_ADD, c1, 32'd22);
    c2 = fresh_key(SLOTS - 1);
    queue_req(FUNC_ADD, c2, 32'd33);
    queue_req(FUNC_GET, c2, $urandom);
    c3 = fresh_key(SLOTS - 1);
    queue_req(FUNC_GET, c3, $urandom);
    queue_req(FUNC_ADD, c1, 32'hffff_ffe0);
    queue_req(FUNC_GET, c1, $urandom);
    queue_req(FUNC_GET, 32'hffff_ffff, $urandom);
    queue_pause();

    for (i = 0; i < 420; i++) begin
      r = $urandom_range(99);
      if (r < 45) queue_req(FUNC_ADD, fresh_key(-1), rand_amount());
      else if (r < 65) queue_req(FUNC_ADD, old_key(), rand_amount());
      else if (r < 85) queue_req(FUNC_GET, old_key(), $urandom);
      else if (r < 95) queue_req(FUNC_GET, fresh_key(-1), $urandom);
      else queue_req(func_e'($urandom_range(1)), ReservedKey, $urandom);
    end
    queue_pause();

    while (key_list.size() < SLOTS) begin
      r = $urandom_range(99);
      if (r < 85) queue_req(FUNC_ADD, fresh_key(-1), rand_amount());
      else if (r < 92) queue_req(FUNC_ADD, old_key(), rand_amount());
      else queue_req(FUNC_GET, old_key(), $urandom);
    end
    queue_pause();

    for (i = 0; i < 300; i++) begin
      r = $urandom_range(99);
      if (r < 30) queue_req(FUNC_ADD, fresh_key(-1), rand_amount());
      else if (r < 45) queue_req(FUNC_GET, fresh_key(-1), $urandom);
      else if (r < 70) queue_req(FUNC_ADD, old_key(), rand_amount());
      else if (r < 95) queue_req(FUNC_GET, old_key(), $urandom);
      else queue_req(func_e'($urandom_range(1)), ReservedKey, $urandom);
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (req_q.size() != 0 || in_valid || pending_results.size() != 0)
      @(posedge clk_i);
    repeat (64) @(posedge clk_i);

    $display("Sent %0d requests, checked %0d results and filled all %0d slots.",
             n_accepted, n_results, SLOTS);
    $display("Seen %0d hits, %0d table-full adds and %0d reserved keys; %0d mismatches.",
             n_hits, n_full, n_rsvd, n_errors);
    if (n_errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
